// ----- rtl/slif_pkg.sv -----
// Package for the sorted leaf insert/find block.
// Holds item and result struct types, the status codes and the action codes; no dependencies.
package slif_pkg;

  // Status codes of a result item
  localparam logic [2:0] StFound     = 3'd0;
  localparam logic [2:0] StNotFound  = 3'd1;
  localparam logic [2:0] StInserted  = 3'd2;
  localparam logic [2:0] StFull      = 3'd3;
  localparam logic [2:0] StDuplicate = 3'd4;

  // Action codes of an input item
  localparam logic ActFind   = 1'b0;
  localparam logic ActInsert = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] key;
    logic [63:0] value_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  index;
    logic [63:0] value_out;
    logic [4:0]  count;
  } res_t;

endpackage

// ----- rtl/sorted_leaf_insert_find_top.sv -----
// Sorted leaf node with binary search find and ordered insert.
// Depends on slif_pkg for the item/result types and status codes.
//
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  ----------------------
// item      in         start & !busy at rising edge  item_i   (slif_pkg::in_t)
// result    out        done_o high for one cycle     result_o (slif_pkg::res_t)
//
// Steps: one memory read port is shared by search and shift. Each binary
// search step is a read state and then a compare state. An insert then moves
// each shifted cell with a read of cell i-1 and a write of cell i, and ends
// with a last read and one write of the new cell. busy is high meanwhile.
// Reset empties the node at once; the cell memories need no clearing pass.
// The result strobe cannot be stalled; busy drops with the strobe.
module sorted_leaf_insert_find_top #(
  parameter int MAX_CELLS   = 16,
  parameter int VALUE_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  slif_pkg::in_t    item_i,
  output logic             done_o,
  output slif_pkg::res_t   result_o
);

  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  // Sequencer state codes
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSrchRd = 3'd1;
  localparam logic [2:0] SSrchCm = 3'd2;
  localparam logic [2:0] SDecide = 3'd3;
  localparam logic [2:0] SShftRd = 3'd4;
  localparam logic [2:0] SShftWr = 3'd5;
  localparam logic [2:0] SInsWr  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]          pos_q, pos_d, idx_q, idx_d, cnt_q, cnt_d;
  logic                   hit_q, hit_d;
  logic                   done_q, done_d;
  slif_pkg::in_t          item_q;
  slif_pkg::res_t         res_q, res_d;
  logic [CW:0]            sum;
  logic [CW-1:0]          mid_c;

  // Cell memories, one write port and one read port; the read port is shared by search and shift
  logic [31:0]            key_mem [MAX_CELLS];
  logic [VALUE_WIDTH-1:0] val_mem [MAX_CELLS];
  logic [31:0]            key_rd_q;
  logic [VALUE_WIDTH-1:0] val_rd_q;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;
  logic [31:0]            wr_key;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic                   accept;

  assign accept = start && (state_q == SIdle);
  assign busy   = (state_q != SIdle);
  assign done_o   = done_q;
  assign result_o = res_q;

  // Midpoint of the current search window
  assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c = sum[CW:1];

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // Capture the item payload on accept; register the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      pos_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      done_q  <= done_d;
    end
  end

  // Sequencer: search, decide, shift, write
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    hit_d   = hit_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_addr = mid_c[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_key  = key_rd_q;
    wr_val  = val_rd_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          lo_d    = '0;
          hi_d    = cnt_q;
          hit_d   = 1'b0;
          state_d = SSrchRd;
        end
      end
      // Issue the read of the midpoint cell, or close a miss
      SSrchRd: begin
        if (lo_q == hi_q) begin
          pos_d   = lo_q;
          state_d = SDecide;
        end else begin
          mid_d   = mid_c;
          state_d = SSrchCm;
        end
      end
      // Compare the key against the midpoint cell and narrow the window
      SSrchCm: begin
        if (item_q.key == key_rd_q) begin
          hit_d   = 1'b1;
          pos_d   = mid_q;
          state_d = SDecide;
        end else if (item_q.key < key_rd_q) begin
          hi_d    = mid_q;
          state_d = SSrchRd;
        end else begin
          lo_d    = mid_q + CW'(1);
          state_d = SSrchRd;
        end
      end
      SDecide: begin
        res_d.index     = 5'(pos_q);
        res_d.count     = 5'(cnt_q);
        res_d.value_out = '0;
        if (item_q.action == slif_pkg::ActFind) begin
          if (hit_q) begin
            res_d.status    = slif_pkg::StFound;
            res_d.value_out = 64'(val_rd_q);
          end else begin
            res_d.status = slif_pkg::StNotFound;
          end
          done_d  = 1'b1;
          state_d = SIdle;
        end else if (cnt_q >= CW'(MAX_CELLS)) begin
          res_d.status = slif_pkg::StFull;
          done_d       = 1'b1;
          state_d      = SIdle;
        end else if (hit_q) begin
          res_d.status = slif_pkg::StDuplicate;
          done_d       = 1'b1;
          state_d      = SIdle;
        end else begin
          idx_d   = cnt_q;
          state_d = SShftRd;
        end
      end
      // Read the cell below the hole, or stop at the insertion point
      SShftRd: begin
        rd_addr = AW'(idx_q - CW'(1));
        if (idx_q > pos_q) begin
          state_d = SShftWr;
        end else begin
          state_d = SInsWr;
        end
      end
      // Move the cell up by one and step down
      SShftWr: begin
        wr_en   = 1'b1;
        idx_d   = idx_q - CW'(1);
        state_d = SShftRd;
      end
      // Write the new cell and report
      SInsWr: begin
        wr_en           = 1'b1;
        wr_addr         = pos_q[AW-1:0];
        wr_key          = item_q.key;
        wr_val          = item_q.value_in[VALUE_WIDTH-1:0];
        cnt_d           = cnt_q + CW'(1);
        res_d.status    = slif_pkg::StInserted;
        res_d.index     = 5'(pos_q);
        res_d.value_out = '0;
        res_d.count     = 5'(cnt_q + CW'(1));
        done_d          = 1'b1;
        state_d         = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule
